[hdl/sync_frame_receiver_with_checksum_core_assert.svh]
// ---------------------------------------------------------------------------
// sfr assertion macros
// shared concurrent assertion forms, clocked on clk_i and held off in reset
// ---------------------------------------------------------------------------
`ifndef SYNC_FRAME_RECEIVER_WITH_CHECKSUM_CORE_ASSERT_SVH
`define SYNC_FRAME_RECEIVER_WITH_CHECKSUM_CORE_ASSERT_SVH

// same-cycle implication
`define SFR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfr assertion failed");

// next-cycle implication
`define SFR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfr assertion failed");

`endif

[hdl/sfr_pkg.sv]
// ---------------------------------------------------------------------------
// sfr_pkg
// constants, types and helpers shared by the frame receiver modules
// ---------------------------------------------------------------------------
package sfr_pkg;

  localparam int FRAME_LEN = 64;
  localparam int ADDR_W    = $clog2(FRAME_LEN);
  localparam int CNT_W     = 6;
  localparam int IDX_W     = 6;

  localparam logic [7:0] SYNC_0 = 8'h12;
  localparam logic [7:0] SYNC_1 = 8'h34;
  localparam logic [7:0] SYNC_2 = 8'h56;
  localparam logic [7:0] SYNC_3 = 8'h78;

  localparam logic [CNT_W-1:0] SUM_END  = CNT_W'(FRAME_LEN - 2);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic       take;
    logic       clear;
    logic       drain;
    logic [1:0] sync_sel;
  } sfr_cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic last_pos;
    logic csum_ok;
    logic busy;
  } sfr_sts_t;

  function automatic logic [7:0] sfr_sync_byte(input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = SYNC_0;
      2'd1:    b = SYNC_1;
      2'd2:    b = SYNC_2;
      2'd3:    b = SYNC_3;
      default: b = SYNC_0;
    endcase
    return b;
  endfunction

endpackage

[hdl/sfr_ctrl.sv]
// ---------------------------------------------------------------------------
// sfr_ctrl
// sync hunt, collect and drain sequencing for the frame receiver
// ---------------------------------------------------------------------------
module sfr_ctrl import sfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rx_valid_i,
  output logic     rx_stall_o,
  input  sfr_sts_t sts_i,
  output sfr_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_HUNT0,
    S_HUNT1,
    S_HUNT2,
    S_HUNT3,
    S_COLLECT,
    S_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;
  logic   acc;

  assign acc        = rx_valid_i && !stall_q;
  assign rx_stall_o = stall_q;

  always_comb begin
    state_d        = state_q;
    stall_d        = stall_q;
    cmd_o          = '0;
    case (state_q)
      S_HUNT0: begin
        cmd_o.sync_sel = 2'd0;
        if (acc && sts_i.sync_hit) begin
          cmd_o.take = 1'b1;
          state_d    = S_HUNT1;
        end
      end
      S_HUNT1, S_HUNT2, S_HUNT3: begin
        case (state_q)
          S_HUNT1: cmd_o.sync_sel = 2'd1;
          S_HUNT2: cmd_o.sync_sel = 2'd2;
          default: cmd_o.sync_sel = 2'd3;
        endcase
        if (acc) begin
          if (sts_i.sync_hit) begin
            cmd_o.take = 1'b1;
            case (state_q)
              S_HUNT1: state_d = S_HUNT2;
              S_HUNT2: state_d = S_HUNT3;
              default: state_d = S_COLLECT;
            endcase
          end else begin
            cmd_o.clear = 1'b1;
            state_d     = S_HUNT0;
          end
        end
      end
      S_COLLECT: begin
        if (acc) begin
          cmd_o.take = 1'b1;
          if (sts_i.last_pos) begin
            cmd_o.clear = 1'b1;
            if (sts_i.csum_ok) begin
              cmd_o.drain = 1'b1;
              state_d     = S_DRAIN;
              stall_d     = 1'b1;
            end else begin
              state_d = S_HUNT0;
            end
          end
        end
      end
      S_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = S_HUNT0;
          stall_d = 1'b0;
        end
      end
      default: begin
        cmd_o.clear = 1'b1;
        state_d     = S_HUNT0;
        stall_d     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT0;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

endmodule

[hdl/sfr_dp.sv]
// ---------------------------------------------------------------------------
// sfr_dp
// frame store, checksum pair, and the read-out pipeline for a good frame
// ---------------------------------------------------------------------------
module sfr_dp import sfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       rx_byte_i,
  input  sfr_cmd_t         cmd_i,
  output sfr_sts_t         sts_o,
  output logic             frame_valid_o,
  input  logic             frame_stall_i,
  output logic [7:0]       frame_byte_o,
  output logic [IDX_W-1:0] byte_index_o,
  output logic             last_byte_o
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_LEN - 1);

  logic [7:0]       mem [FRAME_LEN];

  logic [CNT_W-1:0] cnt_q;
  logic [7:0]       sum_a_q, sum_a_d;
  logic [7:0]       sum_b_q, sum_b_d;
  logic             chk_a_q;

  logic             rd_busy_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic             dat_vld_q;
  logic [ADDR_W-1:0] dat_idx_q;
  logic [7:0]       rd_data_q;
  logic             out_vld_q;
  logic [7:0]       out_byte_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_last_q;

  logic             out_rdy, dat_rdy, issue;

  assign sum_a_d = sum_a_q + rx_byte_i;
  assign sum_b_d = sum_b_q + sum_a_d;

  assign sts_o.sync_hit = (rx_byte_i == sfr_sync_byte(cmd_i.sync_sel));
  assign sts_o.last_pos = (cnt_q == LAST_POS);
  assign sts_o.csum_ok  = chk_a_q && (sum_b_q == rx_byte_i);
  assign sts_o.busy     = rd_busy_q || dat_vld_q || out_vld_q;

  assign out_rdy = !out_vld_q || !frame_stall_i;
  assign dat_rdy = !dat_vld_q || out_rdy;
  assign issue   = rd_busy_q && dat_rdy;

  // frame store
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mem[cnt_q[ADDR_W-1:0]] <= rx_byte_i;
    end
    if (issue) begin
      rd_data_q <= mem[rd_addr_q];
      dat_idx_q <= rd_addr_q;
    end
    if (out_rdy && dat_vld_q) begin
      out_byte_q <= rd_data_q;
      out_idx_q  <= IDX_W'(dat_idx_q);
      out_last_q <= (dat_idx_q == LAST_ADDR);
    end
  end

  // count and checksum pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      chk_a_q <= 1'b0;
    end else if (cmd_i.clear) begin
      cnt_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      chk_a_q <= 1'b0;
    end else if (cmd_i.take) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q < SUM_END) begin
        sum_a_q <= sum_a_d;
        sum_b_q <= sum_b_d;
      end
      if (cnt_q == SUM_END) begin
        chk_a_q <= (sum_a_q == rx_byte_i);
      end
    end
  end

  // read-out sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_busy_q <= 1'b0;
      rd_addr_q <= '0;
      dat_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.drain) begin
        rd_busy_q <= 1'b1;
        rd_addr_q <= '0;
      end else if (issue) begin
        if (rd_addr_q == LAST_ADDR) begin
          rd_busy_q <= 1'b0;
        end else begin
          rd_addr_q <= rd_addr_q + 1'b1;
        end
      end
      if (dat_rdy) begin
        dat_vld_q <= issue;
      end
      if (out_rdy) begin
        out_vld_q <= dat_vld_q;
      end
    end
  end

  assign frame_valid_o = out_vld_q;
  assign frame_byte_o  = out_byte_q;
  assign byte_index_o  = out_idx_q;
  assign last_byte_o   = out_last_q;

endmodule

[hdl/sync_frame_receiver_with_checksum_core.sv]
// ---------------------------------------------------------------------------
// sync_frame_receiver_with_checksum_core
// fixed-length frame receiver with sync hunt and fletcher-style check
// ---------------------------------------------------------------------------
// Takes one received byte per beat and hunts for the sync sequence
// 12 34 56 78; a wrong byte drops back to hunting without being rechecked as
// a first sync byte. After sync the rest of a FRAME_LEN byte frame is stored
// in an on-chip frame store while an 8-bit sum pair runs over all bytes but
// the last two. While hunting or collecting one byte is taken every cycle.
// When the last byte completes a frame whose trailing two bytes match the
// sums, the input stalls and the whole frame is read out of the store, one
// byte per cycle while the output is not stalled, with its index and a last
// flag on the final byte; the input stall lasts until the single read port of
// the store has read every byte, its two-stage read-out pipeline has emptied
// and the controller has seen it empty.
// A frame with a bad checksum produces nothing.
// ---------------------------------------------------------------------------
`include "sync_frame_receiver_with_checksum_core_assert.svh"

module sync_frame_receiver_with_checksum_core import sfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  output logic             rx_stall_o,
  input  logic [7:0]       rx_byte_i,
  output logic             frame_valid_o,
  input  logic             frame_stall_i,
  output logic [7:0]       frame_byte_o,
  output logic [IDX_W-1:0] byte_index_o,
  output logic             last_byte_o
);

  sfr_cmd_t cmd;
  sfr_sts_t sts;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .frame_valid_o (frame_valid_o),
    .frame_stall_i (frame_stall_i),
    .frame_byte_o  (frame_byte_o),
    .byte_index_o  (byte_index_o),
    .last_byte_o   (last_byte_o)
  );

  // no new byte is taken while a frame is being read out
  `SFR_ASSERT_IMP(a_stall_on_drain, frame_valid_o, rx_stall_o)
  // the last flag marks only the final frame position
  `SFR_ASSERT_IMP(a_last_idx, frame_valid_o && last_byte_o, byte_index_o == LAST_IDX)
  // a frame read-out starts at position zero
  `SFR_ASSERT_IMP(a_first_idx, $rose(frame_valid_o), byte_index_o == '0)
  // nothing follows the last beat of a frame
  `SFR_ASSERT_NXT(a_end_quiet, frame_valid_o && last_byte_o && !frame_stall_i, !frame_valid_o)

endmodule

[dv/sync_frame_receiver_with_checksum_core_checker.sv]
// ---------------------------------------------------------------------------
// sync_frame_receiver_with_checksum_core_checker
// watches the byte and frame channels, predicts verified frames and compares
// ---------------------------------------------------------------------------
// Every byte accepted on the receive channel is run through a cycle-free
// copy of the sync hunt, frame store and sum pair. A frame whose trailing two
// bytes match the sums queues its bytes as owed frame beats. Every beat taken
// on the frame channel is checked field by field against the oldest owed
// beat; a beat with nothing owed counts as a mismatch too.
// ---------------------------------------------------------------------------
module sync_frame_receiver_with_checksum_core_checker import sfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  input  logic             rx_stall_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             frame_valid_i,
  input  logic             frame_stall_i,
  input  logic [7:0]       frame_byte_i,
  input  logic [IDX_W-1:0] byte_index_i,
  input  logic             last_byte_i,
  output int               mismatch_count_o,
  output int               beats_owed_o
);

  localparam int FLEN = (FRAME_LEN < 8) ? 8 : ((FRAME_LEN > 64) ? 64 : FRAME_LEN);
  localparam logic [31:0] SYNC_WORD = {SYNC_3, SYNC_2, SYNC_1, SYNC_0};

  typedef enum logic [2:0] {
    WAIT_SYNC0,
    WAIT_SYNC1,
    WAIT_SYNC2,
    WAIT_SYNC3,
    COLLECT
  } hunt_phase_e;

  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic             last;
  } frame_beat_t;

  frame_beat_t owed_beats_q [$];
  hunt_phase_e phase;
  int          next_pos;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [7:0]  frame_mem [64];
  int          mismatches = 0;

  function automatic void restart_hunt();
    phase    = WAIT_SYNC0;
    next_pos = 0;
    sum_a    = '0;
    sum_b    = '0;
  endfunction

  function automatic void store_byte(input logic [7:0] b, input int pos);
    frame_mem[pos] = b;
    if (pos < FLEN - 2) begin
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    end
  endfunction

  function automatic void absorb_rx_byte(input logic [7:0] b);
    int pos;
    int k;
    case (phase)
      WAIT_SYNC1, WAIT_SYNC2, WAIT_SYNC3: begin
        if (b == SYNC_WORD[8*int'(phase) +: 8]) begin
          store_byte(b, int'(phase));
          next_pos = int'(phase) + 1;
          phase    = hunt_phase_e'(int'(phase) + 1);
        end else begin
          restart_hunt();
        end
      end
      COLLECT: begin
        pos = (next_pos < 4) ? 4 : next_pos;
        store_byte(b, pos);
        pos++;
        if (pos < FLEN) begin
          next_pos = pos;
        end else begin
          if (sum_a == frame_mem[FLEN-2] && sum_b == frame_mem[FLEN-1]) begin
            for (k = 0; k < FLEN; k++) begin
              owed_beats_q.push_back('{data: frame_mem[k], index: IDX_W'(k),
                                       last: (k == FLEN - 1)});
            end
          end
          restart_hunt();
        end
      end
      default: begin
        restart_hunt();
        if (b == SYNC_0) begin
          store_byte(b, 0);
          next_pos = 1;
          phase    = WAIT_SYNC1;
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: frame beat %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_beat_t want;
    if (!rst_ni) begin
      restart_hunt();
      owed_beats_q.delete();
    end else begin
      if (frame_valid_i && !frame_stall_i) begin
        if (owed_beats_q.size() == 0) begin
          mismatches++;
          $display("%0t: frame beat with none expected, actual byte %h index %0d last %b",
                   $time, frame_byte_i, byte_index_i, last_byte_i);
        end else begin
          want = owed_beats_q.pop_front();
          check_field("byte", want.data, frame_byte_i);
          check_field("index", 8'(want.index), 8'(byte_index_i));
          check_field("last", 8'(want.last), 8'(last_byte_i));
        end
      end
      if (rx_valid_i && !rx_stall_i) begin
        absorb_rx_byte(rx_byte_i);
      end
    end
    beats_owed_o     = owed_beats_q.size();
    mismatch_count_o = mismatches;
  end

endmodule

[dv/sync_frame_receiver_with_checksum_core_test.sv]
// ---------------------------------------------------------------------------
// sync_frame_receiver_with_checksum_core_test
// stimulus and verdict for the sync frame receiver
// ---------------------------------------------------------------------------
// Drives serial bytes in random bursts: a few directed sync hunt cases, then
// mostly well-formed frames with random bodies and correct sum pairs, mixed
// with corrupted checksums, broken sync prefixes and noise. The frame output
// is stalled on a changing pattern. A checker beside the block predicts and
// compares every frame beat; a watchdog ends a run that stops moving.
// ---------------------------------------------------------------------------
module sync_frame_receiver_with_checksum_core_test import sfr_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BYTES   = 170;

  typedef enum int {
    BODY_RANDOM,
    BODY_ZERO,
    BODY_ONES,
    BODY_SYNC_LIKE
  } body_style_e;

  typedef enum int {
    FAULT_NONE,
    FAULT_SUM_A,
    FAULT_SUM_B,
    FAULT_BODY
  } frame_fault_e;

  logic             clk_i;
  logic             rst_ni;
  logic             rx_valid_i;
  logic             rx_stall_o;
  logic [7:0]       rx_byte_i;
  logic             frame_valid_o;
  logic             frame_stall_i;
  logic [7:0]       frame_byte_o;
  logic [IDX_W-1:0] byte_index_o;
  logic             last_byte_o;

  int mismatch_count;
  int beats_owed;
  int bytes_sent;
  int burst_left;
  int quiet_cycles;

  sync_frame_receiver_with_checksum_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_stall_o    (rx_stall_o),
    .rx_byte_i     (rx_byte_i),
    .frame_valid_o (frame_valid_o),
    .frame_stall_i (frame_stall_i),
    .frame_byte_o  (frame_byte_o),
    .byte_index_o  (byte_index_o),
    .last_byte_o   (last_byte_o)
  );

  sync_frame_receiver_with_checksum_core_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_stall_i       (rx_stall_o),
    .rx_byte_i        (rx_byte_i),
    .frame_valid_i    (frame_valid_o),
    .frame_stall_i    (frame_stall_i),
    .frame_byte_i     (frame_byte_o),
    .byte_index_i     (byte_index_o),
    .last_byte_i      (last_byte_o),
    .mismatch_count_o (mismatch_count),
    .beats_owed_o     (beats_owed)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // output stall: windows of no stall, random stall, heavy stall, periodic
  int stall_mode;
  int stall_window;
  int stall_tick;

  always @(negedge clk_i) begin
    if (stall_window == 0) begin
      stall_mode   = $urandom_range(0, 3);
      stall_window = $urandom_range(16, 96);
    end else begin
      stall_window--;
    end
    stall_tick++;
    case (stall_mode)
      1:       frame_stall_i <= 1'($urandom_range(0, 1));
      2:       frame_stall_i <= ($urandom_range(0, 3) != 0);
      3:       frame_stall_i <= (stall_tick % 3 == 0);
      default: frame_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_valid_i && !rx_stall_o) || (frame_valid_o && !frame_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        rx_valid_i <= 1'b0;
        rx_byte_i  <= 8'($urandom);
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (rx_stall_o !== 1'b0);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  function automatic logic [7:0] sync_byte_at(input int k);
    case (k)
      1:       return SYNC_1;
      2:       return SYNC_2;
      3:       return SYNC_3;
      default: return SYNC_0;
    endcase
  endfunction

  task automatic send_frame(input body_style_e style, input frame_fault_e fault);
    logic [7:0] fbuf [FRAME_LEN];
    logic [7:0] a;
    logic [7:0] bsum;
    int k;
    a    = '0;
    bsum = '0;
    for (k = 0; k < FRAME_LEN - 2; k++) begin
      if (k < 4) begin
        fbuf[k] = sync_byte_at(k);
      end else begin
        case (style)
          BODY_ZERO:      fbuf[k] = 8'h00;
          BODY_ONES:      fbuf[k] = 8'hff;
          BODY_SYNC_LIKE: fbuf[k] = sync_byte_at($urandom_range(0, 3));
          default:        fbuf[k] = 8'($urandom);
        endcase
      end
      a    = a + fbuf[k];
      bsum = bsum + a;
    end
    fbuf[FRAME_LEN-2] = a;
    fbuf[FRAME_LEN-1] = bsum;
    case (fault)
      FAULT_SUM_A: fbuf[FRAME_LEN-2] ^= 8'($urandom_range(1, 255));
      FAULT_SUM_B: fbuf[FRAME_LEN-1] ^= 8'($urandom_range(1, 255));
      FAULT_BODY:  fbuf[$urandom_range(4, FRAME_LEN - 3)] ^= 8'($urandom_range(1, 255));
      default:     ;
    endcase
    for (k = 0; k < FRAME_LEN; k++) begin
      put_byte(fbuf[k]);
    end
  endtask

  task automatic send_broken_sync();
    int depth;
    int k;
    depth = $urandom_range(1, 3);
    for (k = 0; k < depth; k++) begin
      put_byte(sync_byte_at(k));
    end
    put_byte(sync_byte_at(depth) ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 12);
    repeat (n) put_byte(8'($urandom));
    // guard byte drops any partial sync back to hunting
    put_byte(8'h00);
  endtask

  function automatic body_style_e pick_body();
    case ($urandom_range(0, 5))
      0:       return BODY_ZERO;
      1:       return BODY_ONES;
      2:       return BODY_SYNC_LIKE;
      default: return BODY_RANDOM;
    endcase
  endfunction

  initial begin
    int pick;
    int frames_sent;
    bit drained_once;
    rst_ni       = 1'b0;
    rx_valid_i   = 1'b0;
    rx_byte_i    = 8'h00;
    bytes_sent   = 0;
    burst_left   = 0;
    frames_sent  = 0;
    drained_once = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // field extremes while hunting
    put_byte(8'h00);
    put_byte(8'hff);
    // a repeated first sync byte is not taken as a fresh start
    put_byte(SYNC_0);
    put_byte(SYNC_0);
    put_byte(SYNC_1);
    // wrong byte at the third and fourth sync positions
    put_byte(SYNC_0);
    put_byte(SYNC_1);
    put_byte(SYNC_0);
    put_byte(SYNC_0);
    put_byte(SYNC_1);
    put_byte(SYNC_2);
    put_byte(SYNC_0);
    put_byte(SYNC_0);
    put_byte(SYNC_1);
    put_byte(SYNC_2);
    put_byte(8'hff);
    put_byte(8'h00);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      pick = (frames_sent == 0) ? 0 : $urandom_range(0, 9);
      if (pick < 6) begin
        send_frame(pick_body(), FAULT_NONE);
        frames_sent++;
      end else if (pick < 8) begin
        send_frame(pick_body(), frame_fault_e'($urandom_range(1, 3)));
      end else if (pick == 8) begin
        send_broken_sync();
      end else begin
        send_noise();
      end
      if (!drained_once && beats_owed != 0) begin
        rx_valid_i <= 1'b0;
        do @(negedge clk_i); while (beats_owed != 0);
        drained_once = 1'b1;
      end
    end

    rx_valid_i <= 1'b0;
    do @(negedge clk_i); while (beats_owed != 0);
    repeat (FRAME_LEN + 16) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
